// ===== rtl/core/rld_pkg.sv =====
// ----------------------------------------------------------------------------
// rld_pkg
// Shared types and constants for the run length byte decoder.
// ----------------------------------------------------------------------------
package rld_pkg;

  localparam int MAX_RUN_DEF = 64;
  localparam int CNT_W       = 7;
  localparam int SYM_W       = 7;
  localparam int BYTE_W      = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_LIT
  } rld_state_t;

  typedef enum logic {
    OP_DIGIT,
    OP_DEC
  } rld_op_t;

  typedef struct packed {
    rld_op_t            op;
    logic [CNT_W-1:0]   a;
    logic [SYM_W-1:0]   digit;
  } rld_alu_req_t;

  // flag: saturation for a digit, "more than one" for a decrement
  typedef struct packed {
    logic [CNT_W-1:0]   value;
    logic               flag;
  } rld_alu_res_t;

endpackage

// ===== rtl/core/rld_alu.sv =====
// ----------------------------------------------------------------------------
// rld_alu
// Shared count unit: digit accumulate with saturation, or decrement with a
// compare against one.
// ----------------------------------------------------------------------------
module rld_alu
  import rld_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  rld_alu_req_t req,
  output rld_alu_res_t res
);

  localparam logic [CNT_W-1:0] MaxRunC = CNT_W'(MAX_RUN);

  logic over;

  always_comb begin
    // any pending count shifted up by seven bits already exceeds the limit
    over = (req.a != '0) || (req.digit > MaxRunC);
    unique case (req.op)
      OP_DIGIT: begin
        res.value = over ? MaxRunC : req.digit;
        res.flag  = over;
      end
      OP_DEC: begin
        res.value = req.a - CNT_W'(1);
        res.flag  = (req.a > CNT_W'(1));
      end
      default: begin
        res.value = '0;
        res.flag  = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/run_length_byte_decoder_top.sv =====
// ----------------------------------------------------------------------------
// run_length_byte_decoder_top
// Decodes a byte stream where high-bit bytes build a base-128 run count and
// other bytes are literal symbols.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries in_code_byte and
//   in_end_of_stream. A request is taken when in_valid is high and in_stall
//   low; in_stall is high while a request is still producing results.
//   Output channel out_valid / out_stall carries out_symbol, out_last and
//   out_count_clamped from a single output register.
//   Steps: a count digit is taken and gives no result. A literal is decoded,
//   then gives copies of the previous symbol, one fewer than a nonzero
//   pending count, then the literal itself; end of stream gives the copies
//   only. One result leaves per cycle while the receiver does not stall; the
//   rate is set by the single shared count unit that decrements the copies.
//   A new request is taken as soon as the sequencer is back in idle, even
//   while the last result still waits in the output register.
//   Receiver stall freezes a valid output register and the run and literal states.
//   Reset (rst_n low, synchronous) clears the pending count, the previous
//   symbol, the clamp flag and the output valid.
// ----------------------------------------------------------------------------
module run_length_byte_decoder_top
  import rld_pkg::*;
#(
  parameter int MAX_RUN = MAX_RUN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_code_byte,
  input  logic              in_end_of_stream,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SYM_W-1:0]  out_symbol,
  output logic              out_last,
  output logic              out_count_clamped
);

  rld_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] pend_r, pend_nxt;
  logic [SYM_W-1:0] prev_r, prev_nxt;
  logic             clamp_r, clamp_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [SYM_W-1:0] run_sym_r, run_sym_nxt;
  logic [SYM_W-1:0] lit_r, lit_nxt;
  logic             has_lit_r, has_lit_nxt;
  logic             run_clamp_r, run_clamp_nxt;
  logic             ov_r, ov_nxt;
  logic [SYM_W-1:0] osym_r, osym_nxt;
  logic             olast_r, olast_nxt;
  logic             oclamp_r, oclamp_nxt;

  rld_alu_req_t alu_req;
  rld_alu_res_t alu_res;
  logic         load;
  logic         take;

  rld_alu #(.MAX_RUN(MAX_RUN)) u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  assign in_stall          = (state_r != ST_IDLE);
  assign take              = in_valid && !in_stall;
  assign load              = !ov_r || !out_stall;
  assign out_valid         = ov_r;
  assign out_symbol        = osym_r;
  assign out_last          = olast_r;
  assign out_count_clamped = oclamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pend_r  <= '0;
      prev_r  <= '0;
      clamp_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      prev_r  <= prev_nxt;
      clamp_r <= clamp_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r       <= rem_nxt;
    run_sym_r   <= run_sym_nxt;
    lit_r       <= lit_nxt;
    has_lit_r   <= has_lit_nxt;
    run_clamp_r <= run_clamp_nxt;
    osym_r      <= osym_nxt;
    olast_r     <= olast_nxt;
    oclamp_r    <= oclamp_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    prev_nxt      = prev_r;
    clamp_nxt     = clamp_r;
    rem_nxt       = rem_r;
    run_sym_nxt   = run_sym_r;
    lit_nxt       = lit_r;
    has_lit_nxt   = has_lit_r;
    run_clamp_nxt = run_clamp_r;
    ov_nxt        = ov_r && out_stall;
    osym_nxt      = osym_r;
    olast_nxt     = olast_r;
    oclamp_nxt    = oclamp_r;

    alu_req.a     = pend_r;
    alu_req.digit = in_code_byte[SYM_W-1:0];
    alu_req.op    = (in_code_byte[BYTE_W-1] && !in_end_of_stream) ? OP_DIGIT : OP_DEC;

    unique case (state_r)
      ST_IDLE: begin
        if (take) begin
          priority if (in_end_of_stream) begin
            if (alu_res.flag) begin
              rem_nxt       = alu_res.value;
              run_sym_nxt   = prev_r;
              has_lit_nxt   = 1'b0;
              run_clamp_nxt = clamp_r;
              state_nxt     = ST_RUN;
            end
            pend_nxt  = '0;
            clamp_nxt = 1'b0;
          end else if (in_code_byte[BYTE_W-1]) begin
            pend_nxt = alu_res.value;
            if (alu_res.flag) begin
              clamp_nxt = 1'b1;
            end
          end else begin
            lit_nxt       = in_code_byte[SYM_W-1:0];
            prev_nxt      = in_code_byte[SYM_W-1:0];
            run_sym_nxt   = prev_r;
            has_lit_nxt   = 1'b1;
            run_clamp_nxt = (pend_r != '0) && clamp_r;
            rem_nxt       = alu_res.value;
            // copies only when the count is above one
            state_nxt     = alu_res.flag ? ST_RUN : ST_LIT;
            pend_nxt      = '0;
            clamp_nxt     = 1'b0;
          end
        end
      end
      ST_RUN: begin
        alu_req.a  = rem_r;
        alu_req.op = OP_DEC;
        if (load) begin
          ov_nxt     = 1'b1;
          osym_nxt   = run_sym_r;
          olast_nxt  = !alu_res.flag && !has_lit_r;
          oclamp_nxt = run_clamp_r;
          rem_nxt    = alu_res.value;
          if (!alu_res.flag) begin
            state_nxt = has_lit_r ? ST_LIT : ST_IDLE;
          end
        end
      end
      ST_LIT: begin
        if (load) begin
          ov_nxt     = 1'b1;
          osym_nxt   = lit_r;
          olast_nxt  = 1'b1;
          oclamp_nxt = run_clamp_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
